// ----- hw/rtl/kpc_pkg.sv -----
// kpc_pkg: shared types and constants for the key press classifier
// used by kpc_cfg, kpc_press, kpc_click and key_press_classifier

package kpc_pkg;

  localparam int unsigned CFG_ADDR_W = 8;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DEBOUNCE = 8'd0,
    REG_MIDDLE   = 8'd1,
    REG_LONG     = 8'd2,
    REG_GAP      = 8'd3
  } reg_index_t;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd3;
  localparam logic [15:0] MIDDLE_RESET   = 16'd100;
  localparam logic [15:0] LONG_RESET     = 16'd200;
  localparam logic [7:0]  GAP_RESET      = 8'd30;

  localparam logic [15:0] HOLD_MAX = 16'hFFFF;
  localparam logic [7:0]  GAP_MAX  = 8'hFF;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] middle_ticks;
    logic [15:0] long_ticks;
    logic [7:0]  gap_ticks;
  } cfg_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_SINGLE = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_MIDDLE = 3'd3,
    EV_LONG   = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_HOLD     = 3'd2,
    PH_WAIT_UP  = 3'd3,
    PH_MIDDLE   = 3'd4
  } press_phase_t;

  typedef enum logic {
    CLICK_WAIT = 1'b0,
    CLICK_GAP  = 1'b1
  } click_phase_t;

endpackage

// ----- hw/rtl/kpc_cfg.sv -----
// kpc_cfg: threshold registers written through the configuration channel
// depends on kpc_pkg

module kpc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [kpc_pkg::CFG_DATA_W-1:0] cfg_data,
  output kpc_pkg::cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= kpc_pkg::DEBOUNCE_RESET;
      cfg.middle_ticks   <= kpc_pkg::MIDDLE_RESET;
      cfg.long_ticks     <= kpc_pkg::LONG_RESET;
      cfg.gap_ticks      <= kpc_pkg::GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      // indexes past the register list are dropped
      case (cfg_addr)
        kpc_pkg::REG_DEBOUNCE: cfg.debounce_ticks <= cfg_data;
        kpc_pkg::REG_MIDDLE:   cfg.middle_ticks   <= cfg_data;
        kpc_pkg::REG_LONG:     cfg.long_ticks     <= cfg_data;
        kpc_pkg::REG_GAP:      cfg.gap_ticks      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/kpc_press.sv -----
// kpc_press: debounce and press length stage, gives short, middle and long events
// depends on kpc_pkg

module kpc_press (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic            pressed,
  input  kpc_pkg::cfg_t   cfg,
  output kpc_pkg::event_t press_ev
);

  kpc_pkg::press_phase_t phase, phase_next;
  logic [15:0] hold_count, hold_count_next, hold_inc;
  logic        middle_seen, middle_seen_next;
  logic        mid_hit, long_hit, deb_hit;

  assign hold_inc = (hold_count == kpc_pkg::HOLD_MAX) ? hold_count : hold_count + 16'd1;
  assign deb_hit  = hold_inc >= cfg.debounce_ticks;
  assign mid_hit  = hold_inc >= cfg.middle_ticks;
  assign long_hit = hold_inc >= cfg.long_ticks;

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      kpc_pkg::PH_IDLE:
        if (pressed) phase_next = kpc_pkg::PH_DEBOUNCE;
      kpc_pkg::PH_DEBOUNCE:
        if (!pressed) phase_next = kpc_pkg::PH_IDLE;
        else if (deb_hit) phase_next = kpc_pkg::PH_HOLD;
      kpc_pkg::PH_HOLD:
        // once past the middle threshold a release keeps counting
        if (!pressed && !middle_seen) phase_next = kpc_pkg::PH_IDLE;
        else if (long_hit) phase_next = kpc_pkg::PH_WAIT_UP;
        else if (mid_hit) phase_next = kpc_pkg::PH_MIDDLE;
      kpc_pkg::PH_WAIT_UP:
        if (!pressed) phase_next = kpc_pkg::PH_IDLE;
      kpc_pkg::PH_MIDDLE:
        phase_next = pressed ? kpc_pkg::PH_HOLD : kpc_pkg::PH_IDLE;
      default:
        phase_next = kpc_pkg::PH_IDLE;
    endcase
  end

  // event and counters
  always_comb begin
    press_ev         = kpc_pkg::EV_NONE;
    hold_count_next  = hold_count;
    middle_seen_next = middle_seen;
    case (phase)
      kpc_pkg::PH_IDLE:
        if (pressed) hold_count_next = '0;
      kpc_pkg::PH_DEBOUNCE:
        if (pressed) hold_count_next = hold_inc;
      kpc_pkg::PH_HOLD:
        if (!pressed && !middle_seen) begin
          press_ev = kpc_pkg::EV_SINGLE;
        end else begin
          hold_count_next = hold_inc;
          if (mid_hit) middle_seen_next = 1'b1;
          if (long_hit) press_ev = kpc_pkg::EV_LONG;
        end
      kpc_pkg::PH_WAIT_UP:
        if (!pressed) begin
          hold_count_next  = '0;
          middle_seen_next = 1'b0;
        end
      kpc_pkg::PH_MIDDLE:
        if (!pressed) begin
          press_ev         = kpc_pkg::EV_MIDDLE;
          hold_count_next  = '0;
          middle_seen_next = 1'b0;
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= kpc_pkg::PH_IDLE;
      hold_count  <= '0;
      middle_seen <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      hold_count  <= hold_count_next;
      middle_seen <= middle_seen_next;
    end
  end

endmodule

// ----- hw/rtl/kpc_click.sv -----
// kpc_click: gap window stage, turns short presses into single or double clicks
// depends on kpc_pkg

module kpc_click (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  kpc_pkg::event_t press_ev,
  input  logic [7:0]      gap_ticks,
  output kpc_pkg::event_t click_ev
);

  kpc_pkg::click_phase_t phase, phase_next;
  logic [7:0] gap_count, gap_count_next, gap_inc;
  logic       gap_done;

  assign gap_inc  = (gap_count == kpc_pkg::GAP_MAX) ? gap_count : gap_count + 8'd1;
  assign gap_done = gap_inc >= gap_ticks;

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      kpc_pkg::CLICK_WAIT:
        if (press_ev == kpc_pkg::EV_SINGLE) phase_next = kpc_pkg::CLICK_GAP;
      kpc_pkg::CLICK_GAP:
        if (press_ev == kpc_pkg::EV_SINGLE || gap_done) phase_next = kpc_pkg::CLICK_WAIT;
    endcase
  end

  // result and gap counter; middle and long are dropped inside the window
  always_comb begin
    click_ev       = kpc_pkg::EV_NONE;
    gap_count_next = gap_count;
    unique case (phase)
      kpc_pkg::CLICK_WAIT:
        if (press_ev == kpc_pkg::EV_SINGLE) gap_count_next = '0;
        else click_ev = press_ev;
      kpc_pkg::CLICK_GAP:
        if (press_ev == kpc_pkg::EV_SINGLE) begin
          click_ev = kpc_pkg::EV_DOUBLE;
        end else begin
          gap_count_next = gap_inc;
          if (gap_done) click_ev = kpc_pkg::EV_SINGLE;
        end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= kpc_pkg::CLICK_WAIT;
      gap_count <= '0;
    end else if (step) begin
      phase     <= phase_next;
      gap_count <= gap_count_next;
    end
  end

endmodule

// ----- hw/rtl/key_press_classifier.sv -----
// key_press_classifier: top level, stream ports, config registers and result register
// depends on kpc_pkg, kpc_cfg, kpc_press, kpc_click
//
// usage:
//   s_tvalid/s_tready/s_tdata carry one key sample per transfer, key level in
//   bit 0 (0 pressed, 1 released). every accepted sample yields exactly one
//   event code on m_tvalid/m_tready/m_tdata, code in bits 2:0
//   (0 none, 1 single, 2 double, 3 middle, 4 long).
//   cfg_valid/cfg_ready/cfg_addr/cfg_data write the thresholds: 0 debounce,
//   1 middle, 2 long, 3 gap (low 8 bits). cfg_ready is always high; other
//   indexes are ignored. write only while no event is pending.
// timing:
//   both classifier stages settle in the cycle a sample is accepted and the
//   code is captured in the output register, and
//   one sample is taken every cycle while the output is free or being drained.
// reset:
//   rst (synchronous) restores the default thresholds, clears all phases and
//   counters and empties the output register.
// stall:
//   while m_tready is low with a code held, s_tready drops and no sample is
//   taken; state only advances on an accepted transfer.

module key_press_classifier (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [0] key_level
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [2:0] event_res
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [kpc_pkg::CFG_DATA_W-1:0] cfg_data
);

  kpc_pkg::cfg_t   cfg;
  kpc_pkg::event_t press_ev, click_ev;
  logic            step;
  logic [2:0]      event_res;

  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  kpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kpc_press u_press (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .pressed  (!s_tdata[0]),
    .cfg      (cfg),
    .press_ev (press_ev)
  );

  kpc_click u_click (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .press_ev  (press_ev),
    .gap_ticks (cfg.gap_ticks),
    .click_ev  (click_ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) event_res <= click_ev;
  end

  assign m_tdata = {5'b0, event_res};

endmodule
